// ===== hdl/urp_pkg.sv =====
// ----------------------------------------------------------------------------
// urp_pkg
// Shared types and constants for the update receiver protocol block.
// ----------------------------------------------------------------------------
`default_nettype none

package urp_pkg;

  localparam int unsigned CNT_W = 16;
  localparam int unsigned SEQ_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0] START_WAIT_RST  = 16'd3000;
  localparam logic [CNT_W-1:0] EXIT_WAIT_RST   = 16'd5000;
  localparam logic [CNT_W-1:0] RESEND_WAIT_RST = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_WAIT  = 2'd0,
    CFG_EXIT_WAIT   = 2'd1,
    CFG_RESEND_WAIT = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_STANDBY   = 3'd1,
    PH_RECEIVING = 3'd2,
    PH_FINISH    = 3'd3,
    PH_CANCEL    = 3'd4,
    PH_STOP      = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    SEND_START  = 2'd0,
    SEND_CONT   = 2'd1,
    SEND_CANCEL = 2'd2
  } send_code_t;

  typedef enum logic [1:0] {
    END_FINISHED = 2'd0,
    END_STOPPED  = 2'd1,
    END_TIMEOUT  = 2'd2
  } end_code_t;

  typedef enum logic [1:0] {
    FRM_DATA   = 2'd0,
    FRM_FINISH = 2'd1,
    FRM_CANCEL = 2'd2,
    FRM_UNDEF  = 2'd3
  } frame_kind_t;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  typedef struct packed {
    logic             command;
    logic             frame_ready;
    logic [1:0]       frame_kind;
    logic [SEQ_W-1:0] frame_seq;
    logic [7:0]       frame_len;
    logic             tx_ok;
  } in_item_t;

  typedef struct packed {
    logic       send_valid;
    logic [1:0] send_code;
    logic       start_event;
    logic       deliver_valid;
    logic [7:0] deliver_len;
    logic       end_valid;
    logic [1:0] end_code;
    logic       clear_rx;
    logic [2:0] phase_now;
  } out_item_t;

  // Reload values handed from the register file to the protocol core.
  typedef struct packed {
    logic [CNT_W-1:0] start_wait_reload;
    logic [CNT_W-1:0] exit_wait_reload;
    logic [CNT_W-1:0] resend_wait_reload;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/urp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// urp_cfg_regs
// Configuration register file holding the three timeout reload values.
// ----------------------------------------------------------------------------
`default_nettype none

module urp_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             wr_en,
  input  wire logic [urp_pkg::CFG_IDX_W-1:0]    wr_index,
  input  wire logic [urp_pkg::CNT_W-1:0]        wr_data,
  output urp_pkg::cfg_t                         cfg
);

  urp_pkg::cfg_t cfg_r;
  urp_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        urp_pkg::CFG_START_WAIT:  cfg_nxt.start_wait_reload  = wr_data;
        urp_pkg::CFG_EXIT_WAIT:   cfg_nxt.exit_wait_reload   = wr_data;
        urp_pkg::CFG_RESEND_WAIT: cfg_nxt.resend_wait_reload = wr_data;
        default: ; // Writes beyond the register list are dropped.
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_wait_reload  <= urp_pkg::START_WAIT_RST;
      cfg_r.exit_wait_reload   <= urp_pkg::EXIT_WAIT_RST;
      cfg_r.resend_wait_reload <= urp_pkg::RESEND_WAIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hdl/urp_core.sv =====
// ----------------------------------------------------------------------------
// urp_core
// Protocol state and the step logic: ticks count the timeouts down,
// polls advance the phase machine, gate requests and check frame order.
// ----------------------------------------------------------------------------
`default_nettype none

module urp_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en,
  input  wire urp_pkg::in_item_t item,
  input  wire urp_pkg::cfg_t     cfg,
  output urp_pkg::out_item_t     res
);

  urp_pkg::phase_t                 phase_r, phase_nxt;
  logic [urp_pkg::SEQ_W-1:0]       frame_cnt_r, frame_cnt_nxt;
  logic [urp_pkg::CNT_W-1:0]       start_wait_r, start_wait_nxt;
  logic [urp_pkg::CNT_W-1:0]       exit_wait_r, exit_wait_nxt;
  logic [urp_pkg::CNT_W-1:0]       resend_wait_r, resend_wait_nxt;
  logic                            send_permit_r, send_permit_nxt;

  // Next state of the phase machine and the counters.
  always_comb begin
    phase_nxt       = phase_r;
    frame_cnt_nxt   = frame_cnt_r;
    start_wait_nxt  = start_wait_r;
    exit_wait_nxt   = exit_wait_r;
    resend_wait_nxt = resend_wait_r;
    send_permit_nxt = send_permit_r;

    if (item.command == urp_pkg::CMD_TICK) begin
      if (resend_wait_r != '0) begin
        resend_wait_nxt = resend_wait_r - 1'b1;
        if (resend_wait_r == {{(urp_pkg::CNT_W-1){1'b0}}, 1'b1}) begin
          send_permit_nxt = 1'b1;
        end
      end
      if (start_wait_r != '0) start_wait_nxt = start_wait_r - 1'b1;
      if (exit_wait_r != '0)  exit_wait_nxt  = exit_wait_r - 1'b1;
    end else begin
      // Every phase that may send a request sends through the same gate.
      if ((phase_r == urp_pkg::PH_STANDBY || phase_r == urp_pkg::PH_RECEIVING ||
           phase_r == urp_pkg::PH_FINISH || phase_r == urp_pkg::PH_CANCEL) &&
          send_permit_r && item.tx_ok) begin
        resend_wait_nxt = cfg.resend_wait_reload;
        send_permit_nxt = 1'b0;
      end

      case (phase_r)
        urp_pkg::PH_IDLE: begin
          phase_nxt = urp_pkg::PH_STANDBY;
        end
        urp_pkg::PH_STANDBY, urp_pkg::PH_RECEIVING: begin
          if (item.frame_ready) begin
            send_permit_nxt = 1'b1;
            start_wait_nxt  = cfg.start_wait_reload;
            exit_wait_nxt   = cfg.exit_wait_reload;
            case (item.frame_kind)
              urp_pkg::FRM_DATA: begin
                if (item.frame_seq != frame_cnt_r) begin
                  phase_nxt = urp_pkg::PH_CANCEL;
                end else begin
                  if (phase_r == urp_pkg::PH_STANDBY &&
                      item.frame_seq == {{(urp_pkg::SEQ_W-1){1'b0}}, 1'b1}) begin
                    phase_nxt = urp_pkg::PH_RECEIVING;
                  end
                  frame_cnt_nxt = frame_cnt_r + 1'b1;
                end
              end
              urp_pkg::FRM_FINISH: phase_nxt = urp_pkg::PH_FINISH;
              urp_pkg::FRM_CANCEL: phase_nxt = urp_pkg::PH_CANCEL;
              default: ; // Undefined kind only restores the permit and reloads the counters.
            endcase
          end else if (phase_r == urp_pkg::PH_STANDBY) begin
            if (start_wait_r == '0) phase_nxt = urp_pkg::PH_STOP;
          end else if (exit_wait_r == '0) begin
            phase_nxt = urp_pkg::PH_CANCEL;
          end
        end
        urp_pkg::PH_CANCEL: begin
          phase_nxt = urp_pkg::PH_STOP;
        end
        urp_pkg::PH_FINISH, urp_pkg::PH_STOP: begin
          phase_nxt      = urp_pkg::PH_IDLE;
          start_wait_nxt = cfg.start_wait_reload;
          exit_wait_nxt  = cfg.exit_wait_reload;
          frame_cnt_nxt  = {{(urp_pkg::SEQ_W-1){1'b0}}, 1'b1};
        end
        default: ;
      endcase
    end
  end

  // Result of the step.
  always_comb begin
    res           = '0;
    res.phase_now = phase_nxt;
    if (item.command == urp_pkg::CMD_POLL) begin
      if (send_permit_r && item.tx_ok) begin
        case (phase_r)
          urp_pkg::PH_STANDBY: begin
            res.send_valid = 1'b1;
            res.send_code  = urp_pkg::SEND_START;
          end
          urp_pkg::PH_RECEIVING: begin
            res.send_valid = 1'b1;
            res.send_code  = (start_wait_r != '0) ? urp_pkg::SEND_CONT
                                                  : urp_pkg::SEND_START;
          end
          urp_pkg::PH_FINISH: begin
            res.send_valid = 1'b1;
            res.send_code  = urp_pkg::SEND_CONT;
          end
          urp_pkg::PH_CANCEL: begin
            res.send_valid = 1'b1;
            res.send_code  = urp_pkg::SEND_CANCEL;
          end
          default: ;
        endcase
      end

      case (phase_r)
        urp_pkg::PH_STANDBY, urp_pkg::PH_RECEIVING: begin
          if (item.frame_ready && item.frame_kind == urp_pkg::FRM_DATA &&
              item.frame_seq == frame_cnt_r) begin
            res.deliver_valid = 1'b1;
            res.deliver_len   = item.frame_len;
            res.start_event   = (phase_r == urp_pkg::PH_STANDBY) &&
                (item.frame_seq == {{(urp_pkg::SEQ_W-1){1'b0}}, 1'b1});
          end else if (!item.frame_ready && phase_r == urp_pkg::PH_STANDBY &&
                       start_wait_r == '0) begin
            res.end_valid = 1'b1;
            res.end_code  = urp_pkg::END_TIMEOUT;
          end
        end
        urp_pkg::PH_FINISH: begin
          res.end_valid = 1'b1;
          res.end_code  = urp_pkg::END_FINISHED;
          res.clear_rx  = 1'b1;
        end
        urp_pkg::PH_STOP: begin
          res.end_valid = 1'b1;
          res.end_code  = urp_pkg::END_STOPPED;
          res.clear_rx  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= urp_pkg::PH_IDLE;
      frame_cnt_r   <= {{(urp_pkg::SEQ_W-1){1'b0}}, 1'b1};
      start_wait_r  <= urp_pkg::START_WAIT_RST;
      exit_wait_r   <= urp_pkg::EXIT_WAIT_RST;
      resend_wait_r <= '0;
      send_permit_r <= 1'b1;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      frame_cnt_r   <= frame_cnt_nxt;
      start_wait_r  <= start_wait_nxt;
      exit_wait_r   <= exit_wait_nxt;
      resend_wait_r <= resend_wait_nxt;
      send_permit_r <= send_permit_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/update_receiver_protocol_fsm.sv =====
// ----------------------------------------------------------------------------
// update_receiver_protocol_fsm
// Receiver side of a firmware-download handshake: phase machine, frame
// sequence check, gated request generation and timeout countdowns.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  in_       input      in_valid / in_ready   in_data   (urp_pkg::in_item_t)
//  out_      output     out_valid / out_ready out_data  (urp_pkg::out_item_t)
//  cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// An item passes from the input register through the step logic into the
// result register; the step logic and the state registers update in the
// same cycle, so one item is accepted every cycle while the result side
// keeps taking. A stalled result register holds the input register, which
// then holds the input channel. Reset is synchronous and active low; it
// empties both stages and loads the reload values and the protocol state
// with their reset values. The configuration port always accepts a transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module update_receiver_protocol_fsm (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire urp_pkg::in_item_t              in_data,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output urp_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [urp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [urp_pkg::CNT_W-1:0]      cfg_data
);

  urp_pkg::cfg_t      cfg;
  urp_pkg::in_item_t  in_item_r;
  logic               in_vld_r, in_vld_nxt;
  urp_pkg::out_item_t step_res;
  urp_pkg::out_item_t out_item_r;
  logic               out_vld_r, out_vld_nxt;
  logic               step_en;

  // Reload values may be written at any time the block is idle.
  assign cfg_ready = 1'b1;

  urp_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The held item steps whenever the result register is free or is being
  // emptied in this same cycle.
  assign step_en  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || step_en;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_ready) begin
      in_vld_nxt = in_valid;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (step_en) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  urp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_item_r),
    .cfg     (cfg),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
    if (step_en) begin
      out_item_r <= step_res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule

`default_nettype wire

// ===== hdl/urp_checker.sv =====
// ----------------------------------------------------------------------------
// urp_checker
// Port-level checks for the update receiver protocol block.
// ----------------------------------------------------------------------------
`default_nettype none

module urp_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire urp_pkg::out_item_t out_data
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A buffer clear comes only with an end report and a return to idle.
  a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clear_rx |->
      out_data.end_valid && out_data.phase_now == urp_pkg::PH_IDLE)
    else $error("clear without end report or idle phase");

  // The start of a transfer is always a delivered frame in receiving phase.
  a_start_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.start_event |->
      out_data.deliver_valid && out_data.phase_now == urp_pkg::PH_RECEIVING)
    else $error("start event without delivery");

  // Codes and lengths are zero when their valid flag is low.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_data.send_valid || out_data.send_code == 2'd0) &&
      (out_data.deliver_valid || out_data.deliver_len == 8'd0) &&
      (out_data.end_valid || out_data.end_code == 2'd0))
    else $error("field set without its valid flag");

endmodule

bind update_receiver_protocol_fsm urp_checker u_urp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== verif/update_receiver_protocol_fsm_test.sv =====
// ----------------------------------------------------------------------------
// update_receiver_protocol_fsm_test
// Self-checking testbench for the download receiver phase machine. A model of
// the receiver, kept in step with every accepted input transfer, predicts each
// result; a checker compares every result transfer against the oldest
// prediction, field by field, under random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module update_receiver_protocol_fsm_test;

  timeunit 1ns;
  timeprecision 1ps;

  // Writes to this index fall outside the register list and must be ignored.
  localparam logic [urp_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // Width of one input item, for drawing fully random items.
  localparam int IN_W = $bits(urp_pkg::in_item_t);

  // The receiver holds off this long during the back-pressure test.
  localparam int HOLD_CYCLES = 60;

  // Worst case is far below this: about 1700 items, each with random idle gaps
  // on either side and its pass through both stages, a handful of drains and
  // one long hold-off.
  localparam int CYCLE_LIMIT = 150000;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  urp_pkg::in_item_t                  in_data = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  urp_pkg::out_item_t                 out_data;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [urp_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [urp_pkg::CNT_W-1:0]          cfg_data = '0;

  update_receiver_protocol_fsm dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Receiver model. It mirrors the block's registers and is advanced once per
  // accepted input transfer, in acceptance order.
  // --------------------------------------------------------------------------
  logic [urp_pkg::CNT_W-1:0] start_reload  = urp_pkg::START_WAIT_RST;
  logic [urp_pkg::CNT_W-1:0] exit_reload   = urp_pkg::EXIT_WAIT_RST;
  logic [urp_pkg::CNT_W-1:0] resend_reload = urp_pkg::RESEND_WAIT_RST;

  urp_pkg::phase_t           rx_phase    = urp_pkg::PH_IDLE;
  logic [urp_pkg::SEQ_W-1:0] rx_seq_next = 8'd1;
  logic [urp_pkg::CNT_W-1:0] start_left  = urp_pkg::START_WAIT_RST;
  logic [urp_pkg::CNT_W-1:0] exit_left   = urp_pkg::EXIT_WAIT_RST;
  logic [urp_pkg::CNT_W-1:0] resend_left = '0;
  logic                      may_send    = 1'b1;

  // Predicted results, oldest first, waiting for their result transfer.
  urp_pkg::out_item_t step_results_q[$];

  int n_items, n_results, n_writes, n_errors;
  int n_requests, n_deliveries, n_ends, n_cycles;

  // Sender and receiver idling switches and the hold-off request.
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_off_req = 1'b0;

  // A request goes out only when both the permit and the transmitter allow
  // it; sending arms the resend countdown and withdraws the permit.
  function automatic void offer_request(inout urp_pkg::out_item_t r,
                                        input urp_pkg::send_code_t code,
                                        input logic ok);
    if (may_send && ok) begin
      resend_left  = resend_reload;
      may_send     = 1'b0;
      r.send_valid = 1'b1;
      r.send_code  = code;
    end
  endfunction

  // Any accepted frame restores the permit and both wait counters before its
  // kind matters. Data frames must carry exactly the expected sequence
  // number; anything else aborts the transfer.
  function automatic void take_frame(inout urp_pkg::out_item_t r,
                                     input urp_pkg::in_item_t it);
    may_send   = 1'b1;
    start_left = start_reload;
    exit_left  = exit_reload;
    case (urp_pkg::frame_kind_t'(it.frame_kind))
      urp_pkg::FRM_DATA: begin
        if (it.frame_seq != rx_seq_next) begin
          rx_phase = urp_pkg::PH_CANCEL;
        end else begin
          if (rx_phase == urp_pkg::PH_STANDBY && it.frame_seq == 8'd1) begin
            r.start_event = 1'b1;
            rx_phase      = urp_pkg::PH_RECEIVING;
          end
          r.deliver_valid = 1'b1;
          r.deliver_len   = it.frame_len;
          rx_seq_next     = rx_seq_next + 8'd1;
        end
      end
      urp_pkg::FRM_FINISH: rx_phase = urp_pkg::PH_FINISH;
      urp_pkg::FRM_CANCEL: rx_phase = urp_pkg::PH_CANCEL;
      default: ;
    endcase
  endfunction

  // End report followed by a protocol reset; the resend countdown and the
  // permit survive it.
  function automatic void restart_protocol(inout urp_pkg::out_item_t r,
                                           input urp_pkg::end_code_t code);
    r.end_valid = 1'b1;
    r.end_code  = code;
    r.clear_rx  = 1'b1;
    rx_phase    = urp_pkg::PH_IDLE;
    start_left  = start_reload;
    exit_left   = exit_reload;
    rx_seq_next = 8'd1;
  endfunction

  function automatic urp_pkg::out_item_t receiver_step(urp_pkg::in_item_t it);
    urp_pkg::out_item_t r;
    r = '0;
    if (it.command == urp_pkg::CMD_TICK) begin
      // A tick only runs the countdowns; the frame fields mean nothing here.
      if (resend_left != 0) begin
        resend_left = resend_left - 1'b1;
        if (resend_left == 0) may_send = 1'b1;
      end
      if (start_left != 0) start_left = start_left - 1'b1;
      if (exit_left != 0) exit_left = exit_left - 1'b1;
    end else begin
      case (rx_phase)
        urp_pkg::PH_IDLE: rx_phase = urp_pkg::PH_STANDBY;
        urp_pkg::PH_STANDBY: begin
          offer_request(r, urp_pkg::SEND_START, it.tx_ok);
          if (it.frame_ready) begin
            take_frame(r, it);
          end else if (start_left == 0) begin
            r.end_valid = 1'b1;
            r.end_code  = urp_pkg::END_TIMEOUT;
            rx_phase    = urp_pkg::PH_STOP;
          end
        end
        urp_pkg::PH_RECEIVING: begin
          // Once the frame gap has run out the receiver falls back to the start request.
          offer_request(r, (start_left != 0) ? urp_pkg::SEND_CONT : urp_pkg::SEND_START,
                        it.tx_ok);
          if (it.frame_ready) take_frame(r, it);
          else if (exit_left == 0) rx_phase = urp_pkg::PH_CANCEL;
        end
        urp_pkg::PH_FINISH: begin
          offer_request(r, urp_pkg::SEND_CONT, it.tx_ok);
          restart_protocol(r, urp_pkg::END_FINISHED);
        end
        urp_pkg::PH_CANCEL: begin
          offer_request(r, urp_pkg::SEND_CANCEL, it.tx_ok);
          rx_phase = urp_pkg::PH_STOP;
        end
        urp_pkg::PH_STOP: restart_protocol(r, urp_pkg::END_STOPPED);
        default: ;
      endcase
    end
    r.phase_now = rx_phase;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checker. Both channels are sampled at the rising edge; the result side is
  // handled first, though a result can never belong to an input transfer of
  // the same edge since the block has two stages.
  // --------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    urp_pkg::out_item_t want;
    urp_pkg::out_item_t fresh;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (step_results_q.size() == 0) begin
          $error("result transfer with no prediction waiting");
          n_errors++;
        end else begin
          want = step_results_q.pop_front();
          check_field("send_valid", want.send_valid, out_data.send_valid);
          check_field("send_code", want.send_code, out_data.send_code);
          check_field("start_event", want.start_event, out_data.start_event);
          check_field("deliver_valid", want.deliver_valid, out_data.deliver_valid);
          check_field("deliver_len", want.deliver_len, out_data.deliver_len);
          check_field("end_valid", want.end_valid, out_data.end_valid);
          check_field("end_code", want.end_code, out_data.end_code);
          check_field("clear_rx", want.clear_rx, out_data.clear_rx);
          check_field("phase_now", want.phase_now, out_data.phase_now);
          n_results++;
        end
      end
      if (in_valid && in_ready) begin
        fresh = receiver_step(in_data);
        step_results_q.push_back(fresh);
        n_requests   += fresh.send_valid;
        n_deliveries += fresh.deliver_valid;
        n_ends       += fresh.end_valid;
      end
    end
  end

  // Cycle counter and watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) n_cycles++;

  initial begin
    wait (n_cycles == CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side. Each result draws its own stall; a hold-off request parks the
  // receiver for a long, fixed stretch so the pipeline fills up.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      stall = rx_idle ? $urandom_range(0, 3) : 0;
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // --------------------------------------------------------------------------
  // Input side helpers.
  // --------------------------------------------------------------------------
  function automatic logic chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Any bit pattern at all, commands and frame fields alike.
  function automatic urp_pkg::in_item_t rand_item();
    return urp_pkg::in_item_t'(IN_W'($urandom()));
  endfunction

  // Ticks carry random frame fields, which the block must ignore.
  function automatic urp_pkg::in_item_t tick_item();
    urp_pkg::in_item_t it;
    it = rand_item();
    it.command = urp_pkg::CMD_TICK;
    return it;
  endfunction

  function automatic urp_pkg::in_item_t poll_item(logic rdy, urp_pkg::frame_kind_t kind,
                                                  logic [7:0] seq, logic [7:0] len,
                                                  logic ok);
    urp_pkg::in_item_t it;
    it.command     = urp_pkg::CMD_POLL;
    it.frame_ready = rdy;
    it.frame_kind  = kind;
    it.frame_seq   = seq;
    it.frame_len   = len;
    it.tx_ok       = ok;
    return it;
  endfunction

  // A poll with no frame; the frame fields are random leftovers.
  function automatic urp_pkg::in_item_t empty_poll(logic ok);
    return poll_item(1'b0, urp_pkg::frame_kind_t'($urandom_range(0, 3)),
                     8'($urandom()), 8'($urandom()), ok);
  endfunction

  // Offers one item and returns once it has been accepted. With follow_seq
  // set, the sequence number is filled in at the falling edge from the
  // model's counter, which by then has seen every earlier transfer.
  task automatic push_step(urp_pkg::in_item_t it, bit follow_seq = 1'b0);
    int gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (follow_seq) it.frame_seq = rx_seq_next;
    in_data  = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    n_items++;
  endtask

  task automatic push_ticks(int count);
    repeat (count) push_step(tick_item());
  endtask

  // Stops offering and waits until every prediction has been matched, then
  // lets the block's two stages run empty.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (step_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [urp_pkg::CFG_IDX_W-1:0] idx,
                           logic [urp_pkg::CNT_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      urp_pkg::CFG_START_WAIT:  start_reload  = val;
      urp_pkg::CFG_EXIT_WAIT:   exit_reload   = val;
      urp_pkg::CFG_RESEND_WAIT: resend_reload = val;
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Registers change only with the block drained.
  task automatic load_reloads(logic [urp_pkg::CNT_W-1:0] sw, logic [urp_pkg::CNT_W-1:0] ew,
                              logic [urp_pkg::CNT_W-1:0] rw);
    settle();
    write_reg(urp_pkg::CFG_START_WAIT, sw);
    write_reg(urp_pkg::CFG_EXIT_WAIT, ew);
    write_reg(urp_pkg::CFG_RESEND_WAIT, rw);
  endtask

  // One download attempt with random content: wake-up, a run of data frames
  // with ticks and empty polls between, then one of several endings or none,
  // and three empty polls to close. A few frames are deliberately wrong.
  task automatic run_session(int frames);
    int pick;
    push_step(empty_poll(chance(70)));
    push_ticks($urandom_range(0, 2));
    for (int i = 0; i < frames; i++) begin
      if (chance(30)) push_ticks($urandom_range(1, 3));
      if (chance(20)) push_step(empty_poll(chance(70)));
      pick = $urandom_range(0, 99);
      if (pick < 6)
        push_step(poll_item(1'b1, urp_pkg::FRM_DATA, 8'($urandom()), 8'($urandom()),
                            chance(70)));
      else if (pick < 10)
        push_step(poll_item(1'b1, urp_pkg::FRM_UNDEF, 8'($urandom()), 8'($urandom()),
                            chance(70)));
      else if (pick < 12)
        push_step(poll_item(1'b1, urp_pkg::FRM_CANCEL, 8'($urandom()), 8'($urandom()),
                            chance(70)));
      else
        push_step(poll_item(1'b1, urp_pkg::FRM_DATA, 8'd0, 8'($urandom()), chance(70)),
                  1'b1);
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      push_step(poll_item(1'b1, urp_pkg::FRM_FINISH, 8'($urandom()), 8'($urandom()),
                          chance(70)));
    end else if (pick < 80) begin
      push_step(poll_item(1'b1, urp_pkg::FRM_CANCEL, 8'($urandom()), 8'($urandom()),
                          chance(70)));
    end else if (pick < 90) begin
      // Silence long enough to run out the short waits.
      push_ticks($urandom_range(1, 25));
      push_step(empty_poll(chance(70)));
    end
    repeat (3) push_step(empty_poll(chance(70)));
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Walks every phase and frame kind once with the reset reload values:
  // ignored frames on ticks and in idle, permit gating, the first data
  // frame, a duplicate frame, a cancel, a finish and a remote cancel.
  task automatic test_protocol_walk();
    push_step(poll_item(1'b1, urp_pkg::FRM_DATA, 8'd1, 8'd7, 1'b1));
    push_step(tick_item());
    push_step(empty_poll(1'b1));
    push_step(empty_poll(1'b1));
    push_step(poll_item(1'b1, urp_pkg::FRM_DATA, 8'd1, 8'hFF, 1'b0));
    push_step(poll_item(1'b1, urp_pkg::FRM_DATA, 8'd2, 8'h00, 1'b1));
    push_step(poll_item(1'b1, urp_pkg::FRM_UNDEF, 8'hFF, 8'hAA, 1'b1));
    push_step(poll_item(1'b1, urp_pkg::FRM_DATA, 8'd2, 8'h55, 1'b1));
    push_step(empty_poll(1'b1));
    push_step(empty_poll(1'b1));
    push_step(empty_poll(1'b0));
    push_step(poll_item(1'b1, urp_pkg::FRM_DATA, 8'd1, 8'h80, 1'b1));
    push_step(poll_item(1'b1, urp_pkg::FRM_FINISH, 8'd0, 8'd0, 1'b1));
    push_step(empty_poll(1'b1));
    push_step(empty_poll(1'b1));
    push_step(poll_item(1'b1, urp_pkg::FRM_CANCEL, 8'd9, 8'd3, 1'b1));
    push_step(empty_poll(1'b1));
    push_step(empty_poll(1'b1));
  endtask

  // Short reload values so both silence limits expire within a few ticks; an
  // out-of-range register write comes first.
  task automatic test_timeouts();
    settle();
    write_reg(CFG_UNUSED_IDX, 16'($urandom()));
    load_reloads(16'd2, 16'd3, 16'd1);
    push_step(empty_poll(1'b1));
    push_step(empty_poll(1'b1));
    push_ticks(2);
    push_step(empty_poll(1'b1));
    push_step(empty_poll(1'b1));
    push_step(empty_poll(1'b1));
    push_step(poll_item(1'b1, urp_pkg::FRM_DATA, 8'd0, 8'h3C, 1'b1), 1'b1);
    push_ticks(3);
    push_step(empty_poll(1'b1));
    push_step(empty_poll(1'b1));
    push_step(empty_poll(1'b1));
  endtask

  // A session long enough for the frame counter to wrap from 255 to 0.
  task automatic test_counter_wrap();
    load_reloads(16'd40, 16'd60, 16'd5);
    push_step(empty_poll(1'b1));
    for (int i = 0; i < 300; i++)
      push_step(poll_item(1'b1, urp_pkg::FRM_DATA, 8'd0, 8'($urandom()), chance(50)),
                1'b1);
    push_step(poll_item(1'b1, urp_pkg::FRM_FINISH, 8'($urandom()), 8'($urandom()), 1'b1));
    repeat (3) push_step(empty_poll(1'b1));
  endtask

  // The receiver stops taking results for a long stretch while the sender
  // keeps offering back to back, so the block must stall its input.
  task automatic test_backpressure();
    settle();
    tx_idle = 1'b0;
    hold_off_req = 1'b1;
    repeat (24) begin
      if (chance(25)) push_step(tick_item());
      else push_step(poll_item(1'b1, urp_pkg::FRM_DATA, 8'd0, 8'($urandom()), chance(70)),
                     1'b1);
    end
    tx_idle = 1'b1;
  endtask

  // Random sessions mixed with random noise under one register setting.
  task automatic run_random_phase(logic [urp_pkg::CNT_W-1:0] sw,
                                  logic [urp_pkg::CNT_W-1:0] ew,
                                  logic [urp_pkg::CNT_W-1:0] rw, bit tx_gaps, bit rx_gaps,
                                  int budget);
    int stop_at;
    load_reloads(sw, ew, rw);
    tx_idle = tx_gaps;
    rx_idle = rx_gaps;
    stop_at = n_items + budget;
    while (n_items < stop_at) begin
      if (chance(12)) push_step(rand_item());
      else run_session($urandom_range(0, 8));
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Several register settings, the extremes among them, with stretches that
  // have no idling on one or both sides.
  task automatic test_random_sessions();
    run_random_phase(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                     16'($urandom_range(0, 6)), 1'b1, 1'b1, 225);
    run_random_phase(16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 225);
    run_random_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 225);
    run_random_phase(16'($urandom()), 16'($urandom()), 16'($urandom()), 1'b0, 1'b1, 225);
    run_random_phase(16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)),
                     16'($urandom_range(1, 20)), 1'b1, 1'b1, 225);
    run_random_phase(urp_pkg::START_WAIT_RST, urp_pkg::EXIT_WAIT_RST,
                     urp_pkg::RESEND_WAIT_RST, 1'b1, 1'b1, 225);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_protocol_walk();
    test_timeouts();
    test_counter_wrap();
    test_backpressure();
    test_random_sessions();

    settle();
    repeat (8) @(posedge clk);

    $display("Ran %0d input items and checked %0d results across %0d register writes.",
             n_items, n_results, n_writes);
    $display("Model saw %0d requests sent, %0d frames delivered and %0d end reports.",
             n_requests, n_deliveries, n_ends);
    if (n_errors == 0 && step_results_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
